// ----- rtl/bfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_pkg: shared types and constants of the bitmap font text rasteriser
// Payload structs, register map, job descriptor and the 5x8 glyph ROM.
// ----------------------------------------------------------------------------
package bfr_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 240;
  localparam int unsigned SCREEN_HEIGHT_DEF = 240;

  localparam int unsigned GlyphCount = 59;
  localparam int unsigned GlyphIdxW  = 6;

  localparam logic [7:0] CHAR_NL          = 8'd10;
  localparam logic [7:0] CHAR_CR          = 8'd13;
  localparam logic [7:0] CHAR_FIRST_GLYPH = 8'd33;  // first code with lit bits
  localparam logic [7:0] CHAR_LAST_GLYPH  = 8'd90;
  localparam logic [7:0] CHAR_SPACE       = 8'd32;

  // register map, byte address = 4 * index
  localparam int unsigned PaddrW = 4;
  localparam logic [1:0] REG_LEFT_MARGIN = 2'd0;
  localparam logic [1:0] REG_TOP_ROW     = 2'd1;
  localparam logic [1:0] REG_SCALE       = 2'd2;
  localparam logic [1:0] REG_INK_COLOR   = 2'd3;

  typedef struct packed {
    logic [7:0] char_code;
    logic       string_start;
  } char_t;

  typedef struct packed {
    logic [7:0]  rect_x;
    logic [7:0]  rect_y;
    logic [7:0]  rect_width;
    logic [7:0]  rect_height;
    logic [15:0] rect_color;
    logic        last_rect;
  } rect_t;

  typedef struct packed {
    logic [15:0] left_margin;
    logic [15:0] top_row;
    logic [7:0]  scale;
    logic [15:0] ink_color;
  } cfg_t;

  // one character to draw, with its cell origin
  typedef struct packed {
    logic [GlyphIdxW-1:0] glyph_idx;
    logic [15:0]          base_col;
    logic [15:0]          base_row;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FLUSH
  } bk_state_e;

  // column 0 in the top byte; within a byte bit 0 is the top row
  localparam logic [39:0] FONT_ROM [GlyphCount] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700,
    40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
    40'h3649552250, 40'h0005030000, 40'h001C224100,
    40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
    40'h4261514946, 40'h2141454B31, 40'h1814127F10,
    40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000,
    40'h0056360000, 40'h0008142241, 40'h1414141414,
    40'h4122140800, 40'h0201510906, 40'h324979413E,
    40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090101,
    40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
    40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
    40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
    40'h1F2040201F, 40'h7F2018207F, 40'h6314081463,
    40'h0304780403, 40'h6151494543
  };

endpackage

// ----- rtl/bfr_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_queue: two-entry job queue
// Decouples the character front end from the glyph scanner.
// ----------------------------------------------------------------------------
module bfr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bfr_pkg::job_t  push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output bfr_pkg::job_t  pop_job_o,
  output logic           empty_o
);
  import bfr_pkg::*;

  job_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o    = (count_q == 2'd2);
  assign empty_o   = (count_q == 2'd0);
  assign pop_job_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ----- rtl/bfr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_front: character front end
// Owns the text cursor, handles newline, carriage return and wrap, and
// queues a job for every character that has lit glyph bits while scale is nonzero.
// ----------------------------------------------------------------------------
module bfr_front #(
  parameter int unsigned SCREEN_WIDTH = bfr_pkg::SCREEN_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bfr_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bfr_pkg::char_t in_data_i,
  output logic           push_o,
  output bfr_pkg::job_t  push_job_o,
  input  logic           full_i
);
  import bfr_pkg::*;

  localparam logic [16:0] ScrW = 17'(SCREEN_WIDTH);

  logic [15:0]          cur_col_q, cur_col_d;
  logic [15:0]          cur_row_q, cur_row_d;
  logic [15:0]          base_col, base_row, adv_col, down_row;
  logic [10:0]          six_s, eight_s;
  logic                 wrap, accept;
  logic [GlyphIdxW-1:0] glyph_idx;
  logic [7:0]           code;

  assign code       = in_data_i.char_code;
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign six_s    = {1'b0, cfg_i.scale, 2'b00} + {2'b00, cfg_i.scale, 1'b0};
  assign eight_s  = {cfg_i.scale, 3'b000};
  assign base_col = in_data_i.string_start ? cfg_i.left_margin : cur_col_q;
  assign base_row = in_data_i.string_start ? cfg_i.top_row : cur_row_q;
  assign adv_col  = base_col + 16'(six_s);
  assign down_row = base_row + 16'(eight_s);
  // wrap test after advancing, compared without wrap-around
  assign wrap     = ({1'b0, adv_col} + 17'(six_s)) > ScrW;

  // space, unprintable and codes past the font all map to the blank glyph
  assign glyph_idx = (code >= CHAR_FIRST_GLYPH && code <= CHAR_LAST_GLYPH) ?
                     GlyphIdxW'(code - CHAR_SPACE) : '0;

  assign push_o = accept && (glyph_idx != '0) && (cfg_i.scale != 8'd0);
  assign push_job_o.glyph_idx = glyph_idx;
  assign push_job_o.base_col  = base_col;
  assign push_job_o.base_row  = base_row;

  always_comb begin
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    if (accept) begin
      if (code == CHAR_NL) begin
        cur_col_d = cfg_i.left_margin;
        cur_row_d = down_row;
      end else if (code == CHAR_CR) begin
        cur_col_d = base_col;
        cur_row_d = base_row;
      end else if (wrap) begin
        cur_col_d = cfg_i.left_margin;
        cur_row_d = down_row;
      end else begin
        cur_col_d = adv_col;
        cur_row_d = base_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= 16'd0;
      cur_row_q <= 16'd0;
    end else begin
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
    end
  end

endmodule

// ----- rtl/bfr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_back: glyph scanner
// Walks the 40 glyph bits of a job, one per cycle unless the output stalls,
// and emits a clipped rectangle per visible lit bit. One rectangle is held
// back so that the final one of a character can be flagged.
// ----------------------------------------------------------------------------
module bfr_back #(
  parameter int unsigned SCREEN_WIDTH  = bfr_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = bfr_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bfr_pkg::cfg_t  cfg_i,
  input  logic           empty_i,
  input  bfr_pkg::job_t  pop_job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bfr_pkg::rect_t out_data_o
);
  import bfr_pkg::*;

  localparam logic [16:0] ScrW = 17'(SCREEN_WIDTH);
  localparam logic [16:0] ScrH = 17'(SCREEN_HEIGHT);

  bk_state_e   state_q, state_d;
  logic [39:0] glyph_q, font_word;
  logic [2:0]  col_q, row_q;
  logic [15:0] x_q, y_q, base_row_q;
  rect_t       held_q, out_q, cand, held_flagged;
  logic        held_v_q, out_v_q;
  logic        hit, stall, advance, last_bit, out_free, load_out;

  assign font_word = FONT_ROM[pop_job_i.glyph_idx];
  assign out_free  = !out_v_q || out_ready_i;
  assign last_bit  = (col_q == 3'd4) && (row_q == 3'd7);

  always_comb begin
    cand.rect_x      = x_q[7:0];
    cand.rect_y      = y_q[7:0];
    cand.rect_width  = cfg_i.scale;
    cand.rect_height = cfg_i.scale;
    cand.rect_color  = cfg_i.ink_color;
    cand.last_rect   = 1'b0;
    if (({1'b0, x_q} + 17'(cfg_i.scale)) > ScrW) begin
      cand.rect_width = 8'(ScrW - {1'b0, x_q});
    end
    if (({1'b0, y_q} + 17'(cfg_i.scale)) > ScrH) begin
      cand.rect_height = 8'(ScrH - {1'b0, y_q});
    end
  end

  // held rectangle is the last of its character once the scan has finished
  always_comb begin
    held_flagged           = held_q;
    held_flagged.last_rect = (state_q == BK_FLUSH);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (!empty_i) state_d = BK_SCAN;
      BK_SCAN:  if (advance && last_bit) state_d = BK_FLUSH;
      BK_FLUSH: if (!held_v_q || out_free) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    pop_o    = 1'b0;
    hit      = 1'b0;
    stall    = 1'b0;
    advance  = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        pop_o = !empty_i;
      end
      BK_SCAN: begin
        hit      = glyph_q[0] && ({1'b0, x_q} < ScrW) && ({1'b0, y_q} < ScrH);
        stall    = hit && held_v_q && !out_free;
        advance  = !stall;
        load_out = hit && held_v_q && out_free;
      end
      BK_FLUSH: begin
        load_out = held_v_q && out_free;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      held_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      col_q    <= 3'd0;
      row_q    <= 3'd0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (advance && hit) begin
        held_v_q <= 1'b1;
      end else if (state_q == BK_FLUSH && out_free) begin
        held_v_q <= 1'b0;
      end
      if (pop_o) begin
        col_q <= 3'd0;
        row_q <= 3'd0;
      end else if (advance) begin
        row_q <= row_q + 3'd1;
        if (row_q == 3'd7) begin
          col_q <= col_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= held_flagged;
    end
    if (advance && hit) begin
      held_q <= cand;
    end
    if (pop_o) begin
      // reorder so bit 0 is column 0 top row and bits follow scan order
      glyph_q    <= {font_word[7:0], font_word[15:8], font_word[23:16],
                     font_word[31:24], font_word[39:32]};
      x_q        <= pop_job_i.base_col;
      y_q        <= pop_job_i.base_row;
      base_row_q <= pop_job_i.base_row;
    end else if (advance) begin
      glyph_q <= {1'b0, glyph_q[39:1]};
      if (row_q == 3'd7) begin
        x_q <= x_q + 16'(cfg_i.scale);
        y_q <= base_row_q;
      end else begin
        y_q <= y_q + 16'(cfg_i.scale);
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/bitmap_font_text_rasterizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_font_text_rasterizer: 5x8 bitmap font text rasteriser
// Turns a stream of character bytes into scaled, clipped pixel rectangles.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one character per
//   transaction; string_start reloads the cursor from left_margin/top_row.
//   Output channel (out_valid_o/out_ready_i/out_data_o) carries one rectangle
//   per transaction; last_rect marks the final rectangle of a character.
//   The front end updates the cursor as it takes each character; a
//   two-entry queue feeds the glyph scanner, which visits the 40 glyph bits
//   at one per cycle while the output is not stalled. A drawn character
//   passes through the scanner's pop, 40-bit scan and final flush steps;
//   newline, carriage return and blank characters never reach the scanner.
//   A rectangle moves to the output register when the next visible lit bit
//   is scanned, or in the flush state for the last one, so the first
//   rectangle of a character waits in the held register before it appears.
//   A stalled receiver holds the output register; the scanner keeps one more
//   rectangle and then stops, and the queue fills before in_ready_o drops.
//   Reset: cursor 0,0, scale 1, ink colour white, margins 0. The user must
//   write registers over the APB port only while idle; the block won't check.
// ----------------------------------------------------------------------------
module bitmap_font_text_rasterizer #(
  parameter int unsigned SCREEN_WIDTH  = bfr_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = bfr_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bfr_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  bfr_pkg::char_t             in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output bfr_pkg::rect_t             out_data_o
);
  import bfr_pkg::*;

  cfg_t       cfg_q;
  logic       cfg_wr;
  logic [1:0] reg_idx;
  logic       q_push, q_pop, q_full, q_empty;
  job_t       q_push_job, q_pop_job;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_LEFT_MARGIN: prdata = {16'd0, cfg_q.left_margin};
      REG_TOP_ROW:     prdata = {16'd0, cfg_q.top_row};
      REG_SCALE:       prdata = {24'd0, cfg_q.scale};
      REG_INK_COLOR:   prdata = {16'd0, cfg_q.ink_color};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_margin <= 16'd0;
      cfg_q.top_row     <= 16'd0;
      cfg_q.scale       <= 8'd1;
      cfg_q.ink_color   <= 16'hFFFF;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LEFT_MARGIN: cfg_q.left_margin <= pwdata[15:0];
        REG_TOP_ROW:     cfg_q.top_row     <= pwdata[15:0];
        REG_SCALE:       cfg_q.scale       <= pwdata[7:0];
        REG_INK_COLOR:   cfg_q.ink_color   <= pwdata[15:0];
        default:         cfg_q.scale       <= cfg_q.scale;
      endcase
    end
  end

  bfr_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (q_push),
    .push_job_o (q_push_job),
    .full_i     (q_full)
  );

  bfr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (q_push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_job_o  (q_pop_job),
    .empty_o    (q_empty)
  );

  bfr_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (q_empty),
    .pop_job_i   (q_pop_job),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("job queue read while empty");

  a_rect_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.rect_width != 8'd0 && out_data_o.rect_height != 8'd0))
    else $error("rectangle with no area");

  a_queued_job_drawable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_push_job.glyph_idx != '0 && cfg_q.scale != 8'd0))
    else $error("blank job queued");
`endif

endmodule
